@@ rtl/bve_pkg.sv @@
`default_nettype none
package bve_pkg;

	localparam int FB = 12;
	localparam int ONE = 1 << FB;
	localparam int HALF = 1 << (FB - 1);

	localparam int IDW = 144;
	localparam int ODW = 144;
	localparam int CIW = 3;
	localparam int CW = 48;

	localparam int VW = 34;
	localparam int SW = 30;
	localparam int L2W = 2 * SW + 2;
	localparam int RW = L2W + 1;
	localparam int SQ_STEPS = L2W / 2 + 1;
	localparam int LW = SW + 1;
	localparam int NW = SW + FB + 1;
	localparam int QB = FB + 1;
	localparam int UW = FB + 2;
	localparam int UXW = 18;
	localparam int PW = 48;

	localparam int THR_SPH = (1 << (2 * FB)) / 1000000;
	localparam int THR_CYL = (1 << (2 * FB)) / 10000;
	localparam int TW = $clog2(THR_CYL + 1);

	localparam int NORM_LAT = 4 + SQ_STEPS + 1 + QB + 1;

	typedef enum logic [1:0] {
		MODE_FIXED = 2'd0,
		MODE_SPH   = 2'd1,
		MODE_CYL   = 2'd2
	} mode_t;

	typedef enum logic [CIW-1:0] {
		CFG_EYE_X       = 3'd0,
		CFG_EYE_Y       = 3'd1,
		CFG_EYE_Z       = 3'd2,
		CFG_GT_X        = 3'd3,
		CFG_GT_Z        = 3'd4,
		CFG_FALLBACK_R  = 3'd5,
		CFG_FALLBACK_UP = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0][VW-1:0] v;
		logic [TW-1:0]      thr;
	} nrm_in_t;

	typedef struct packed {
		logic [2:0][UW-1:0] u;
		logic               ok;
	} nrm_out_t;

	typedef struct packed {
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] az;
		logic [15:0] offr;
		logic [15:0] offu;
		mode_t       mode;
	} side_t;

	// Product rounded to nearest, half away from zero.
	function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] bias;
		bias = p[PW-1] ? PW'(HALF - 1) : PW'(HALF);
		return (p + bias) >>> FB;
	endfunction

	function automatic logic [15:0] sat16(input logic signed [VW-1:0] x);
		if (&x[VW-1:15] || ~|x[VW-1:15]) begin
			return x[15:0];
		end
		return x[VW-1] ? 16'h8000 : 16'h7FFF;
	endfunction

endpackage
`default_nettype wire

@@ rtl/bve_norm.sv @@
`default_nettype none
module bve_norm (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire bve_pkg::nrm_in_t  din,
	output bve_pkg::nrm_out_t      dout
);
	import bve_pkg::*;

	localparam int SHW = $clog2(VW - SW + 1);

	typedef struct packed {
		logic [2:0][SW-1:0] ms;
		logic [2:0]         sgn;
		logic               tiny;
	} sqs_t;

	typedef struct packed {
		logic [2:0][NW-1:0] rm;
		logic [2:0][QB-1:0] q;
		logic [2:0]         sgn;
		logic [LW-1:0]      len;
		logic               ok;
	} dvs_t;

	logic [2:0][VW-1:0]   mag_a;
	logic [2:0]           sgn_a;
	logic [TW-1:0]        thr_a;
	logic [2:0][SW-1:0]   ms_b;
	logic [2:0]           sgn_b;
	logic                 z_b;
	logic [TW-1:0]        thr_b;
	logic [2:0][2*SW-1:0] sq_c;
	logic [2:0][SW-1:0]   ms_c;
	logic [2:0]           sgn_c;
	logic                 z_c;
	logic [TW-1:0]        thr_c;
	logic [RW-1:0]        sx_q [0:SQ_STEPS];
	logic [RW-1:0]        sr_q [0:SQ_STEPS];
	sqs_t                 sb_q [0:SQ_STEPS];
	dvs_t                 dv_q [0:QB];
	nrm_out_t             out_q;
	logic [VW-1:0]        orv;
	logic [SHW-1:0]       shv;
	logic [L2W-1:0]       sum_c;
	logic [LW-1:0]        len_e;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sgn_a[i] <= din.v[i][VW-1];
				mag_a[i] <= din.v[i][VW-1] ? VW'(-din.v[i]) : din.v[i];
			end
			thr_a <= din.thr;
		end
	end

	always_comb begin
		orv = mag_a[0] | mag_a[1] | mag_a[2];
		shv = '0;
		for (int j = SW; j < VW; j++) begin
			if (orv[j]) begin
				shv = SHW'(j - SW + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ms_b[i] <= SW'(mag_a[i] >> shv);
			end
			sgn_b <= sgn_a;
			z_b <= (shv == '0);
			thr_b <= thr_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_c[i] <= ms_b[i] * ms_b[i];
			end
			ms_c <= ms_b;
			sgn_c <= sgn_b;
			z_c <= z_b;
			thr_c <= thr_b;
		end
	end

	assign sum_c = L2W'(sq_c[0]) + L2W'(sq_c[1]) + L2W'(sq_c[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			sx_q[0] <= RW'(sum_c);
			sr_q[0] <= '0;
			sb_q[0].ms <= ms_c;
			sb_q[0].sgn <= sgn_c;
			sb_q[0].tiny <= z_c && (sum_c <= L2W'(thr_c));
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [RW-1:0] BITV = RW'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [RW-1:0] trial;
		assign trial = sr_q[k] + BITV;
		always_ff @(posedge clk) begin
			if (en) begin
				if (sx_q[k] >= trial) begin
					sx_q[k+1] <= sx_q[k] - trial;
					sr_q[k+1] <= (sr_q[k] >> 1) + BITV;
				end else begin
					sx_q[k+1] <= sx_q[k];
					sr_q[k+1] <= sr_q[k] >> 1;
				end
				sb_q[k+1] <= sb_q[k];
			end
		end
	end

	assign len_e = sr_q[SQ_STEPS][LW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_q[0].rm[i] <= NW'({sb_q[SQ_STEPS].ms[i], {FB{1'b0}}}) + NW'(len_e >> 1);
			end
			dv_q[0].q <= '0;
			dv_q[0].sgn <= sb_q[SQ_STEPS].sgn;
			dv_q[0].len <= len_e;
			dv_q[0].ok <= !sb_q[SQ_STEPS].tiny && (len_e != '0);
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int K = QB - 1 - j;
		logic [NW-1:0] den;
		logic [2:0]    hit;
		assign den = NW'(dv_q[j].len) << K;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				hit[i] = (dv_q[j].rm[i] >= den);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_q[j+1].rm[i] <= hit[i] ? dv_q[j].rm[i] - den : dv_q[j].rm[i];
					dv_q[j+1].q[i] <= {dv_q[j].q[i][QB-2:0], hit[i]};
				end
				dv_q[j+1].sgn <= dv_q[j].sgn;
				dv_q[j+1].len <= dv_q[j].len;
				dv_q[j+1].ok <= dv_q[j].ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				out_q.u[i] <= dv_q[QB].sgn[i] ? -UW'(dv_q[QB].q[i]) : UW'(dv_q[QB].q[i]);
			end
			out_q.ok <= dv_q[QB].ok;
		end
	end

	assign dout = out_q;

endmodule
`default_nettype wire

@@ rtl/billboard_vertex_expand_unit.sv @@
// Channel  Direction  Bits    Carries
// s_*      in         144+2   one billboard vertex, facing mode in tuser
// m_*      out        144     corner position and lighting direction
// cfg_*    in         3+48    register write: index and value
//
// One vertex is accepted every cycle while the output is not stalled.
// The pipeline holds two chained normalize units of 51 stages each, built
// from a 32-step square root and a 13-step divider.
// Reset clears the valid bits and loads the register defaults.
// When a result is not taken the whole pipeline holds; nothing is lost.
`default_nettype none
module billboard_vertex_expand_unit (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// anchor_x, anchor_y, anchor_z, spread_right, rise_up, origin_x, origin_z
	input  wire logic [bve_pkg::IDW-1:0] s_tdata,
	// facing_mode
	input  wire logic [1:0]              s_tuser,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// pos_x, pos_y, pos_z, light_x, light_y, light_z
	output logic [bve_pkg::ODW-1:0]      m_tdata,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [bve_pkg::CIW-1:0] cfg_index,
	input  wire logic [bve_pkg::CW-1:0]  cfg_data
);
	import bve_pkg::*;

	localparam int DL = 2 * NORM_LAT;

	logic en;

	logic signed [31:0] eye_x_q, eye_y_q, eye_z_q, gt_x_q, gt_z_q;
	logic [31:0]        fb_right_q;
	logic [47:0]        fb_up_q;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic [DL-1:0]      vl_q;

	side_t              side_s1, side_s2, side_s3;
	logic signed [31:0] ox_s1, oz_s1;
	logic signed [32:0] wx_s2, wz_s2;
	logic [2:0][VW-1:0] v_s3;
	logic [TW-1:0]      thr_s3;

	side_t              dl_q [0:DL-1];
	logic [2:0][15:0]   lr_q [0:DL-1];
	nrm_out_t           fd_q [0:NORM_LAT-1];
	nrm_in_t            n1_in, n2_in;
	nrm_out_t           n1_out, n2_out;

	side_t              sd;
	nrm_out_t           fo;
	logic signed [15:0] f0, f1, f2, fbrx, fbrz;
	logic signed [15:0] rx_c, rz_c;
	logic [2:0][15:0]   up_c, lt_c;
	logic               use_c;

	side_t              side_s4, side_s5, side_s6, side_s7;
	logic signed [15:0] rx_s4, rz_s4, rx_s5, rz_s5, rx_s6, rz_s6;
	logic [2:0][15:0]   up_s4, up_s5;
	logic [2:0][15:0]   f_s4;
	logic               use_s4, use_s5;
	logic [2:0][15:0]   lt_s4, lt_s5, lt_s6, lt_s7;
	logic signed [31:0] pa_s5, pb_s5, pc_s5, pd_s5;
	logic signed [UXW-1:0] ux_s6, uy_s6, uz_s6;
	logic signed [PW-1:0]  uyd;
	logic signed [UXW+15:0] prx_s7, prz_s7, pux_s7, puy_s7, puz_s7;
	logic [31:0]        px_s8, py_s8, pz_s8;
	logic [2:0][15:0]   lt_s8;

	assign en = !vld_s8 || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q <= '0;
			eye_y_q <= '0;
			eye_z_q <= '0;
			gt_x_q <= '0;
			gt_z_q <= '0;
			fb_right_q <= 32'(ONE);
			fb_up_q <= 48'(ONE) << 16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_EYE_X: eye_x_q <= cfg_data[31:0];
				CFG_EYE_Y: eye_y_q <= cfg_data[31:0];
				CFG_EYE_Z: eye_z_q <= cfg_data[31:0];
				CFG_GT_X: gt_x_q <= cfg_data[31:0];
				CFG_GT_Z: gt_z_q <= cfg_data[31:0];
				CFG_FALLBACK_R: fb_right_q <= cfg_data[31:0];
				CFG_FALLBACK_UP: fb_up_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vl_q <= '0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vl_q <= {vl_q[DL-2:0], vld_s3};
			vld_s4 <= vl_q[DL-1];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.ax <= s_tdata[15:0];
			side_s1.ay <= s_tdata[31:16];
			side_s1.az <= s_tdata[47:32];
			side_s1.offr <= s_tdata[63:48];
			side_s1.offu <= s_tdata[79:64];
			case (s_tuser)
				MODE_FIXED: side_s1.mode <= MODE_FIXED;
				MODE_SPH: side_s1.mode <= MODE_SPH;
				default: side_s1.mode <= MODE_CYL;
			endcase
			ox_s1 <= s_tdata[111:80];
			oz_s1 <= s_tdata[143:112];

			side_s2 <= side_s1;
			wx_s2 <= 33'($signed(side_s1.ax)) + 33'(ox_s1);
			wz_s2 <= 33'($signed(side_s1.az)) + 33'(oz_s1);

			side_s3 <= side_s2;
			case (side_s2.mode)
				MODE_SPH: begin
					v_s3[0] <= VW'(eye_x_q) - VW'(wx_s2);
					v_s3[1] <= VW'(eye_y_q) - VW'($signed(side_s2.ay));
					v_s3[2] <= VW'(eye_z_q) - VW'(wz_s2);
					thr_s3 <= TW'(THR_SPH);
				end
				default: begin
					v_s3[0] <= VW'(gt_x_q) - VW'(wx_s2);
					v_s3[1] <= '0;
					v_s3[2] <= VW'(gt_z_q) - VW'(wz_s2);
					thr_s3 <= TW'(THR_CYL);
				end
			endcase
		end
	end

	assign n1_in.v = v_s3;
	assign n1_in.thr = thr_s3;

	bve_norm u_norm_view (
		.clk  (clk),
		.en   (en),
		.din  (n1_in),
		.dout (n1_out)
	);

	assign n2_in.v[0] = -VW'($signed(n1_out.u[2]));
	assign n2_in.v[1] = '0;
	assign n2_in.v[2] = VW'($signed(n1_out.u[0]));
	assign n2_in.thr = TW'(THR_SPH);

	bve_norm u_norm_right (
		.clk  (clk),
		.en   (en),
		.din  (n2_in),
		.dout (n2_out)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dl_q[0] <= side_s3;
			for (int i = 0; i < 3; i++) begin
				lr_q[0][i] <= sat16($signed(v_s3[i]));
			end
			for (int i = 1; i < DL; i++) begin
				dl_q[i] <= dl_q[i-1];
				lr_q[i] <= lr_q[i-1];
			end
			fd_q[0] <= n1_out;
			for (int i = 1; i < NORM_LAT; i++) begin
				fd_q[i] <= fd_q[i-1];
			end
		end
	end

	assign sd = dl_q[DL-1];
	assign fo = fd_q[NORM_LAT-1];
	assign f0 = 16'($signed(fo.u[0]));
	assign f1 = 16'($signed(fo.u[1]));
	assign f2 = 16'($signed(fo.u[2]));
	assign fbrx = fb_right_q[15:0];
	assign fbrz = fb_right_q[31:16];

	always_comb begin
		rx_c = 16'(ONE);
		rz_c = '0;
		up_c = {16'd0, 16'(ONE), 16'd0};
		lt_c = {16'(ONE), 16'(HALF), 16'd0};
		use_c = 1'b0;
		case (sd.mode)
			MODE_FIXED: begin
			end
			MODE_SPH: begin
				if (fo.ok) begin
					use_c = 1'b1;
					lt_c = {f2, f1, f0};
					if (n2_out.ok) begin
						rx_c = 16'($signed(n2_out.u[0]));
						rz_c = 16'($signed(n2_out.u[2]));
					end
				end else begin
					rx_c = fbrx;
					rz_c = fbrz;
					up_c = {fb_up_q[47:32], fb_up_q[31:16], fb_up_q[15:0]};
					lt_c = lr_q[DL-1];
				end
			end
			default: begin
				if (fo.ok) begin
					rx_c = -f2;
					rz_c = f0;
				end else begin
					rx_c = fbrx;
					rz_c = fbrz;
				end
				lt_c = {sat16(-VW'(rz_c)), 16'(HALF), sat16(-VW'(rx_c))};
			end
		endcase
	end

	assign uyd = rnd(PW'(pb_s5)) - rnd(PW'(pc_s5));

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= sd;
			rx_s4 <= rx_c;
			rz_s4 <= rz_c;
			up_s4 <= up_c;
			f_s4 <= {f2, f1, f0};
			use_s4 <= use_c;
			lt_s4 <= lt_c;

			side_s5 <= side_s4;
			rx_s5 <= rx_s4;
			rz_s5 <= rz_s4;
			up_s5 <= up_s4;
			use_s5 <= use_s4;
			lt_s5 <= lt_s4;
			pa_s5 <= $signed(f_s4[1]) * rz_s4;
			pb_s5 <= $signed(f_s4[2]) * rx_s4;
			pc_s5 <= $signed(f_s4[0]) * rz_s4;
			pd_s5 <= $signed(f_s4[1]) * rx_s4;

			side_s6 <= side_s5;
			rx_s6 <= rx_s5;
			rz_s6 <= rz_s5;
			lt_s6 <= lt_s5;
			if (use_s5) begin
				ux_s6 <= UXW'(rnd(PW'(pa_s5)));
				uy_s6 <= UXW'(uyd);
				uz_s6 <= UXW'(-rnd(PW'(pd_s5)));
			end else begin
				ux_s6 <= UXW'($signed(up_s5[0]));
				uy_s6 <= UXW'($signed(up_s5[1]));
				uz_s6 <= UXW'($signed(up_s5[2]));
			end

			side_s7 <= side_s6;
			lt_s7 <= lt_s6;
			prx_s7 <= $signed(side_s6.offr) * rx_s6;
			prz_s7 <= $signed(side_s6.offr) * rz_s6;
			pux_s7 <= $signed(side_s6.offu) * ux_s6;
			puy_s7 <= $signed(side_s6.offu) * uy_s6;
			puz_s7 <= $signed(side_s6.offu) * uz_s6;

			px_s8 <= 32'(PW'($signed(side_s7.ax)) + rnd(PW'(prx_s7)) + rnd(PW'(pux_s7)));
			py_s8 <= 32'(PW'($signed(side_s7.ay)) + rnd(PW'(puy_s7)));
			pz_s8 <= 32'(PW'($signed(side_s7.az)) + rnd(PW'(prz_s7)) + rnd(PW'(puz_s7)));
			lt_s8 <= lt_s7;
		end
	end

	assign m_tvalid = vld_s8;
	assign m_tdata = {lt_s8[2], lt_s8[1], lt_s8[0], pz_s8, py_s8, px_s8};

endmodule
`default_nettype wire

@@ rtl/bve_checker.sv @@
`default_nettype none
module bve_checker (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    s_tvalid,
	input wire logic                    s_tready,
	input wire logic                    m_tvalid,
	input wire logic                    m_tready,
	input wire logic [bve_pkg::ODW-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Output item dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("Output item changed while stalled.");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("Input stalled with an empty output stage.");

	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("Input stalled while the output item is being taken.");

endmodule

bind billboard_vertex_expand_unit bve_checker u_bve_checker (.*);
`default_nettype wire
